// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the merge block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge while reset is released.
`define KWM_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("merge block assertion failed");

// Checked on every rising clock edge, reset included.
`define KWM_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) (prop)) \
    else $error("merge block assertion failed");

`endif

// ----- hw/rtl/kwm_pkg.sv -----
// ----------------------------------------------------------------------------
// kwm_pkg
// Command and status types shared by the merge controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kwm_pkg;

  typedef struct packed {
    logic capture;
    logic load_wr;
    logic pos_init;
    logic root_rd;
    logic refill_wr;
    logic node_rd;
    logic node_sel;
    logic node_wr;
    logic climb;
    logic rpt_sel;
    logic out_load;
  } kwm_cmd_t;

  typedef struct packed {
    logic n_is_one;
    logic root_live;
    logic climb_empty;
    logic pos_is_one;
    logic out_free;
  } kwm_sts_t;

endpackage

// ----- hw/rtl/winner_tree_kway_merge.sv -----
// ----------------------------------------------------------------------------
// winner_tree_kway_merge
// Tournament winner tree that merges up to MAX_WAYS sorted runs.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Contents
// s_axis    in         tuser: opcode, key_present; tdata: way, sort_key, record_tag
// m_axis    out        tuser: merge_done; tdata: winner_way, winner_key, winner_tag
// cfg       in         ways_in_use, written when cfg_we_i is high
//
// A load transaction writes one leaf. A build replays every internal node and a
// refill, if the winner's leaf is live, writes it and replays the nodes above it,
// one per tree level; each node costs a tree read, a leaf key read and a compare
// with write-back through the single match unit.
// The output register holds one result; a full output register stalls only the
// final report step. Reset clears the live flags, the output valid and sets
// the run count to MAX_WAYS.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module winner_tree_kway_merge
  import kwm_pkg::*;
#(
  parameter int unsigned MAX_WAYS = 16,
  parameter int unsigned KEY_BITS = 64,
  parameter int unsigned TAG_BITS = 32,
  localparam int unsigned WAY_W   = $clog2(MAX_WAYS),
  localparam int unsigned CNT_W   = $clog2(MAX_WAYS + 1),
  localparam int unsigned DATA_W  = ((WAY_W + KEY_BITS + TAG_BITS + 7) / 8) * 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [DATA_W-1:0] s_axis_tdata,  // way, sort_key, record_tag, zero pad
  input  logic [2:0]        s_axis_tuser,  // opcode, key_present
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [DATA_W-1:0] m_axis_tdata,  // winner_way, winner_key, winner_tag, zero pad
  output logic              m_axis_tuser,  // merge_done
  input  logic              cfg_we_i,
  input  logic [CNT_W-1:0]  cfg_wdata_i
);

  kwm_cmd_t            cmd;
  kwm_sts_t            sts;
  logic [WAY_W-1:0]    out_way;
  logic [KEY_BITS-1:0] out_key;
  logic [TAG_BITS-1:0] out_tag;

  kwm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .opcode_i   (s_axis_tuser[1:0]),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  kwm_dpath #(
    .MAX_WAYS (MAX_WAYS),
    .KEY_BITS (KEY_BITS),
    .TAG_BITS (TAG_BITS)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_way_i     (s_axis_tdata[WAY_W-1:0]),
    .in_key_i     (s_axis_tdata[WAY_W +: KEY_BITS]),
    .in_tag_i     (s_axis_tdata[WAY_W + KEY_BITS +: TAG_BITS]),
    .in_present_i (s_axis_tuser[2]),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_way_o    (out_way),
    .out_key_o    (out_key),
    .out_tag_o    (out_tag),
    .out_done_o   (m_axis_tuser)
  );

  assign m_axis_tdata = DATA_W'({out_tag, out_key, out_way});

endmodule

// ----- hw/rtl/kwm_dpath.sv -----
// ----------------------------------------------------------------------------
// kwm_dpath
// Leaf and tree storage, match logic, position counter and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kwm_dpath
  import kwm_pkg::*;
#(
  parameter int unsigned MAX_WAYS = 16,
  parameter int unsigned KEY_BITS = 64,
  parameter int unsigned TAG_BITS = 32,
  localparam int unsigned WAY_W   = $clog2(MAX_WAYS),
  localparam int unsigned NODE_W  = $clog2(2 * MAX_WAYS),
  localparam int unsigned CNT_W   = $clog2(MAX_WAYS + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  kwm_cmd_t            cmd_i,
  output kwm_sts_t            sts_o,
  input  logic                cfg_we_i,
  input  logic [CNT_W-1:0]    cfg_wdata_i,
  input  logic [WAY_W-1:0]    in_way_i,
  input  logic [KEY_BITS-1:0] in_key_i,
  input  logic [TAG_BITS-1:0] in_tag_i,
  input  logic                in_present_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [WAY_W-1:0]    out_way_o,
  output logic [KEY_BITS-1:0] out_key_o,
  output logic [TAG_BITS-1:0] out_tag_o,
  output logic                out_done_o
);

  function automatic logic live_at(input logic [WAY_W-1:0]    w,
                                   input logic [CNT_W-1:0]    n,
                                   input logic [MAX_WAYS-1:0] live);
    return (NODE_W'(w) < NODE_W'(n)) && live[w];
  endfunction

  logic [KEY_BITS-1:0] key_mem [MAX_WAYS];
  logic [TAG_BITS-1:0] tag_mem [MAX_WAYS];
  logic [WAY_W-1:0]    tree_mem [MAX_WAYS];

  logic [CNT_W-1:0]    n_q, n_d;
  logic [MAX_WAYS-1:0] live_q, live_d;
  logic                out_valid_q, out_valid_d;
  logic [NODE_W-1:0]   pos_q, pos_d;

  logic [KEY_BITS-1:0] key_q;
  logic [TAG_BITS-1:0] tag_q;
  logic                present_q;
  logic [WAY_W-1:0]    w_q, l_q, r_q;
  logic [WAY_W-1:0]    tree_a_q, tree_b_q;
  logic [KEY_BITS-1:0] key_a_q, key_b_q;
  logic [TAG_BITS-1:0] tag_rd_q;
  logic [WAY_W-1:0]    out_way_q;
  logic [KEY_BITS-1:0] out_key_q;
  logic [TAG_BITS-1:0] out_tag_q;
  logic                out_done_q;

  logic [NODE_W-1:0]   n_node, two_p, two_p1, leaf_pos, climb_pos;
  logic [WAY_W-1:0]    root_w, l_val, r_val, win, tree_rd_a, leaf_rd_a, leaf_waddr;
  logic                root_live, load_ok, leaf_we, l_live, r_live, w_live;
  logic [KEY_BITS-1:0] leaf_wkey;
  logic [TAG_BITS-1:0] leaf_wtag;
  logic                leaf_wlive;

  assign n_node    = NODE_W'(n_q);
  assign root_w    = (n_q == CNT_W'(1)) ? '0 : tree_a_q;
  assign root_live = live_at(root_w, n_q, live_q);
  assign two_p     = {pos_q[NODE_W-2:0], 1'b0};
  assign two_p1    = {pos_q[NODE_W-2:0], 1'b1};
  assign tree_rd_a = cmd_i.root_rd ? WAY_W'(1) : two_p[WAY_W-1:0];
  assign leaf_pos  = NODE_W'(root_w) + n_node;
  assign climb_pos = leaf_pos >> 1;

  always_comb begin
    l_val = (two_p >= n_node) ? WAY_W'(two_p - n_node) : tree_a_q;
    r_val = (two_p1 >= n_node) ? WAY_W'(two_p1 - n_node) : tree_b_q;
  end

  assign leaf_rd_a = cmd_i.node_sel ? l_val : root_w;

  always_comb begin
    l_live = live_at(l_q, n_q, live_q);
    r_live = live_at(r_q, n_q, live_q);
    if (l_live && r_live) begin
      win = (key_a_q <= key_b_q) ? l_q : r_q;
    end else if (r_live) begin
      win = r_q;
    end else begin
      win = l_q;
    end
  end

  assign load_ok    = NODE_W'(in_way_i) < NODE_W'(MAX_WAYS);
  assign leaf_we    = (cmd_i.load_wr && load_ok) || (cmd_i.refill_wr && root_live);
  assign leaf_waddr = cmd_i.load_wr ? in_way_i : root_w;
  assign leaf_wkey  = cmd_i.load_wr ? in_key_i : key_q;
  assign leaf_wtag  = cmd_i.load_wr ? in_tag_i : tag_q;
  assign leaf_wlive = cmd_i.load_wr ? in_present_i : present_q;
  assign w_live     = live_at(w_q, n_q, live_q);

  always_comb begin
    n_d = n_q;
    if (cfg_we_i) begin
      if (cfg_wdata_i == '0) begin
        n_d = CNT_W'(1);
      end else if (cfg_wdata_i > CNT_W'(MAX_WAYS)) begin
        n_d = CNT_W'(MAX_WAYS);
      end else begin
        n_d = cfg_wdata_i;
      end
    end
  end

  always_comb begin
    live_d = live_q;
    if (leaf_we) begin
      live_d[leaf_waddr] = leaf_wlive;
    end
  end

  always_comb begin
    pos_d = pos_q;
    if (cmd_i.pos_init) begin
      pos_d = n_node - NODE_W'(1);
    end else if (cmd_i.refill_wr) begin
      pos_d = climb_pos;
    end else if (cmd_i.node_wr) begin
      pos_d = cmd_i.climb ? (pos_q >> 1) : (pos_q - NODE_W'(1));
    end
  end

  assign sts_o.out_free = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign sts_o.n_is_one    = (n_q == CNT_W'(1));
  assign sts_o.root_live   = root_live;
  assign sts_o.climb_empty = (climb_pos == '0);
  assign sts_o.pos_is_one  = (pos_q == NODE_W'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q         <= CNT_W'(MAX_WAYS);
      live_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      n_q         <= n_d;
      live_q      <= live_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (leaf_we) begin
      key_mem[leaf_waddr] <= leaf_wkey;
      tag_mem[leaf_waddr] <= leaf_wtag;
    end
    if (cmd_i.node_wr) begin
      tree_mem[pos_q[WAY_W-1:0]] <= win;
    end
    if (cmd_i.root_rd || cmd_i.node_rd) begin
      tree_a_q <= tree_mem[tree_rd_a];
    end
    if (cmd_i.node_rd) begin
      tree_b_q <= tree_mem[two_p1[WAY_W-1:0]];
    end
    if (cmd_i.node_sel || cmd_i.rpt_sel) begin
      key_a_q <= key_mem[leaf_rd_a];
    end
    if (cmd_i.node_sel) begin
      key_b_q <= key_mem[r_val];
    end
    if (cmd_i.rpt_sel) begin
      tag_rd_q <= tag_mem[root_w];
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    if (cmd_i.capture) begin
      key_q     <= in_key_i;
      tag_q     <= in_tag_i;
      present_q <= in_present_i;
    end
    if (cmd_i.node_sel) begin
      l_q <= l_val;
      r_q <= r_val;
    end
    if (cmd_i.rpt_sel) begin
      w_q <= root_w;
    end
    if (cmd_i.out_load) begin
      if (w_live) begin
        out_way_q  <= w_q;
        out_key_q  <= key_a_q;
        out_tag_q  <= tag_rd_q;
        out_done_q <= 1'b0;
      end else begin
        out_way_q  <= '0;
        out_key_q  <= '0;
        out_tag_q  <= '0;
        out_done_q <= 1'b1;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_way_o   = out_way_q;
  assign out_key_o   = out_key_q;
  assign out_tag_o   = out_tag_q;
  assign out_done_o  = out_done_q;

endmodule

// ----- hw/rtl/kwm_ctrl.sv -----
// ----------------------------------------------------------------------------
// kwm_ctrl
// Sequencer for load, build and refill transactions of the merge block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module kwm_ctrl
  import kwm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] opcode_i,
  input  kwm_sts_t   sts_i,
  output kwm_cmd_t   cmd_o
);

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_BUILD  = 2'd1;
  localparam logic [1:0] OP_REFILL = 2'd2;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_ROOT_T = 9'b000000010,
    S_ROOT_W = 9'b000000100,
    S_NODE_A = 9'b000001000,
    S_NODE_B = 9'b000010000,
    S_NODE_C = 9'b000100000,
    S_RPT_T  = 9'b001000000,
    S_RPT_W  = 9'b010000000,
    S_RPT_O  = 9'b100000000
  } kwm_state_e;

  kwm_state_e state_q, state_d;
  logic       mode_q, mode_d;
  logic       accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    mode_d  = mode_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.capture = 1'b1;
          unique case (opcode_i)
            OP_LOAD: begin
              cmd_o.load_wr = 1'b1;
            end
            OP_BUILD: begin
              mode_d = 1'b0;
              if (sts_i.n_is_one) begin
                state_d = S_RPT_T;
              end else begin
                cmd_o.pos_init = 1'b1;
                state_d        = S_NODE_A;
              end
            end
            OP_REFILL: begin
              mode_d  = 1'b1;
              state_d = S_ROOT_T;
            end
            default: begin
            end
          endcase
        end
      end
      S_ROOT_T: begin
        cmd_o.root_rd = 1'b1;
        state_d       = S_ROOT_W;
      end
      S_ROOT_W: begin
        cmd_o.refill_wr = 1'b1;
        if (sts_i.root_live && !sts_i.climb_empty) begin
          state_d = S_NODE_A;
        end else begin
          state_d = S_RPT_T;
        end
      end
      S_NODE_A: begin
        cmd_o.node_rd = 1'b1;
        state_d       = S_NODE_B;
      end
      S_NODE_B: begin
        cmd_o.node_sel = 1'b1;
        state_d        = S_NODE_C;
      end
      S_NODE_C: begin
        cmd_o.node_wr = 1'b1;
        cmd_o.climb   = mode_q;
        state_d       = sts_i.pos_is_one ? S_RPT_T : S_NODE_A;
      end
      S_RPT_T: begin
        cmd_o.root_rd = 1'b1;
        state_d       = S_RPT_W;
      end
      S_RPT_W: begin
        cmd_o.rpt_sel = 1'b1;
        state_d       = S_RPT_O;
      end
      S_RPT_O: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mode_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
    end
  end

  `KWM_ASSERT(a_state_onehot, $onehot(state_q))
  `KWM_ASSERT(a_out_load_free, cmd_o.out_load |-> sts_i.out_free)
  `KWM_ASSERT(a_build_leaves_idle,
              (accept && opcode_i == OP_BUILD) |=> (state_q != S_IDLE))
  `KWM_ASSERT(a_refill_reads_root,
              (accept && opcode_i == OP_REFILL) |=> (state_q == S_ROOT_T))

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the winner tree k-way merge.
// A short directed sequence loads extreme heads, builds, refills to completion
// and replays a stale tree under a smaller run count. Randomised merges of
// sorted runs follow, with noise, broken refills and random run count settings,
// while both streams idle at random. Each result transaction is checked field
// by field against a behavioural model of the tree kept in the testbench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned WAYS          = 16;
  localparam int unsigned DATA_W        = 104;
  localparam int unsigned PLAN          = 0;
  localparam int unsigned SEEN          = 1;
  localparam int unsigned TARGET_ITEMS  = 1500;
  localparam int unsigned SETTLE_CYCLES = 64;
  localparam int unsigned CYCLE_LIMIT   = 1000000;
  localparam int unsigned MAX_RUN       = 6;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_BUILD  = 2'd1,
    OP_REFILL = 2'd2,
    OP_IDLE   = 2'd3
  } merge_op_e;

  typedef struct packed {
    merge_op_e   op;
    logic [3:0]  way;
    logic [63:0] key;
    logic [31:0] tag;
    logic        present;
  } merge_item_t;

  typedef struct packed {
    logic [3:0]  way;
    logic [63:0] key;
    logic [31:0] tag;
    logic        done;
  } merge_result_t;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [DATA_W-1:0] s_axis_tdata  = '0;
  logic [2:0]        s_axis_tuser  = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [DATA_W-1:0] m_axis_tdata;
  logic              m_axis_tuser;
  logic              cfg_we_i      = 1'b0;
  logic [4:0]        cfg_wdata_i   = '0;

  // Two copies of the tree: one steers the stimulus, one follows the port.
  logic [63:0] leaf_key [2][WAYS];
  logic [31:0] leaf_tag [2][WAYS];
  bit          leaf_live [2][WAYS];
  logic [3:0]  node_way [2][WAYS];
  logic [4:0]  ways_reg [2] = '{5'd16, 5'd16};

  logic [4:0]  first_counts [6] = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd17, 5'd2};

  merge_item_t   pending_items [$];
  merge_result_t expected_winners [$];
  merge_item_t   drive_item;
  merge_item_t   seen_item;
  merge_result_t seen_result;
  merge_result_t want_result;

  int unsigned in_issued, in_taken, out_taken, out_seen;
  int unsigned in_gap, out_stall, cycle_count, errors, items_posted, max_built;
  bit          in_burst, out_burst;

  logic [63:0] run_key [WAYS][MAX_RUN];
  logic [31:0] run_tag [WAYS][MAX_RUN];
  int unsigned run_len [WAYS];
  int unsigned run_head [WAYS];

  winner_tree_kway_merge i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  function automatic int active_ways(int c);
    if (ways_reg[c] == 0) return 1;
    if (ways_reg[c] > WAYS) return WAYS;
    return int'(ways_reg[c]);
  endfunction

  function automatic bit run_live(int c, int w, int n);
    return (w < n) && leaf_live[c][w];
  endfunction

  function automatic int slot_way(int c, int j, int n);
    if (j >= n) return j - n;
    return int'(node_way[c][j]);
  endfunction

  function automatic int play_match(int c, int l, int r, int n);
    bit ll, rl;
    ll = run_live(c, l, n);
    rl = run_live(c, r, n);
    if (ll && rl) return (leaf_key[c][l] <= leaf_key[c][r]) ? l : r;
    if (rl) return r;
    return l;
  endfunction

  function automatic void replay(int c, int p, int n);
    node_way[c][p] = 4'(play_match(c, slot_way(c, 2 * p, n), slot_way(c, 2 * p + 1, n), n));
  endfunction

  function automatic bit merge_step(int c, merge_item_t it, output merge_result_t res);
    int n, w, pos;
    n   = active_ways(c);
    res = '0;
    if (it.op == OP_LOAD) begin
      leaf_key[c][it.way]  = it.key;
      leaf_tag[c][it.way]  = it.tag;
      leaf_live[c][it.way] = it.present;
      return 1'b0;
    end
    if (it.op == OP_IDLE) return 1'b0;
    if (it.op == OP_BUILD) begin
      for (int p = n - 1; p > 0; p--) replay(c, p, n);
    end else begin
      w = slot_way(c, 1, n);
      if (run_live(c, w, n)) begin
        leaf_key[c][w]  = it.key;
        leaf_tag[c][w]  = it.tag;
        leaf_live[c][w] = it.present;
        pos = w + n;
        while (pos > 1) begin
          pos = pos / 2;
          replay(c, pos, n);
        end
      end
    end
    w = slot_way(c, 1, n);
    if (run_live(c, w, n)) begin
      res.way = 4'(w);
      res.key = leaf_key[c][w];
      res.tag = leaf_tag[c][w];
    end else begin
      res.done = 1'b1;
    end
    return 1'b1;
  endfunction

  function automatic logic [63:0] rand_key();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] step_key(logic [63:0] k, int unsigned mode);
    logic [63:0] d, s;
    case (mode)
      0: d = 64'($urandom_range(0, 2));
      1: d = rand_key() >> $urandom_range(4, 63);
      default: d = 64'($urandom_range(0, 1000));
    endcase
    s = k + d;
    return (s < k) ? '1 : s;
  endfunction

  function automatic void post_item(merge_op_e op, logic [3:0] way, logic [63:0] key,
                                    logic [31:0] tag, logic present,
                                    output merge_result_t res);
    merge_item_t it;
    it.op      = op;
    it.way     = way;
    it.key     = key;
    it.tag     = tag;
    it.present = present;
    if (op == OP_BUILD && active_ways(PLAN) > max_built) max_built = active_ways(PLAN);
    if (op != OP_IDLE) items_posted++;
    void'(merge_step(PLAN, it, res));
    pending_items.push_back(it);
  endfunction

  function automatic void check_field(string field, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      errors++;
    end
  endfunction

  task automatic wait_drained();
    while (pending_items.size() != 0 || in_taken != in_issued ||
           expected_winners.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_ways(logic [4:0] value);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    ways_reg[PLAN] = value;
  endtask

  task automatic run_merge();
    merge_result_t res, junk;
    int unsigned   n, mode, w, turns;
    logic [63:0]   k;
    n    = active_ways(PLAN);
    mode = $urandom_range(0, 2);
    for (int i = 0; i < WAYS; i++) begin
      run_len[i]  = (i < n) ? $urandom_range(0, $urandom_range(0, MAX_RUN)) : 0;
      run_head[i] = 0;
      k = (mode == 0) ? 64'($urandom_range(0, 3)) : (mode == 1) ? rand_key() : rand_key() >> 1;
      for (int j = 0; j < MAX_RUN; j++) begin
        run_key[i][j] = k;
        run_tag[i][j] = $urandom;
        k = step_key(k, mode);
      end
    end
    for (int i = 0; i < n; i++) begin
      post_item(OP_LOAD, 4'(i), (run_len[i] != 0) ? run_key[i][0] : rand_key(),
                run_tag[i][0], run_len[i] != 0, junk);
      run_head[i] = (run_len[i] != 0) ? 1 : 0;
    end
    if (n < WAYS && $urandom_range(0, 3) == 0) begin
      post_item(OP_LOAD, 4'($urandom_range(n, WAYS - 1)), rand_key(), $urandom,
                1'($urandom_range(0, 1)), junk);
    end
    post_item(OP_BUILD, 4'($urandom), rand_key(), $urandom, 1'($urandom_range(0, 1)), res);
    turns = 0;
    while (!res.done && turns < 200) begin
      turns++;
      case ($urandom_range(0, 39))
        0: post_item(OP_IDLE, 4'($urandom), rand_key(), $urandom, 1'($urandom_range(0, 1)),
                     junk);
        1: post_item(OP_LOAD, 4'($urandom), rand_key(), $urandom, 1'($urandom_range(0, 1)),
                     junk);
        2: post_item(OP_REFILL, 4'($urandom), rand_key(), $urandom,
                     1'($urandom_range(0, 1)), res);
        default: begin
          w = 32'(res.way);
          if (run_head[w] < run_len[w]) begin
            post_item(OP_REFILL, 4'($urandom), run_key[w][run_head[w]], run_tag[w][run_head[w]],
                      1'b1, res);
            run_head[w]++;
          end else begin
            post_item(OP_REFILL, 4'($urandom), rand_key(), $urandom, 1'b0, res);
          end
        end
      endcase
    end
    repeat ($urandom_range(0, 2)) begin
      post_item(OP_REFILL, 4'($urandom), rand_key(), $urandom, 1'($urandom_range(0, 1)), res);
    end
  endtask

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb_top: FAIL");
    $finish;
  end

  always @(negedge clk_i) begin
    if (rst_ni && !(s_axis_tvalid && in_taken != in_issued)) begin
      if (in_gap != 0) begin
        in_gap = in_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        drive_item = pending_items.pop_front();
        s_axis_tdata  <= {4'b0, drive_item.tag, drive_item.key, drive_item.way};
        s_axis_tuser  <= {drive_item.present, drive_item.op};
        s_axis_tvalid <= 1'b1;
        in_issued = in_issued + 1;
        if ($urandom_range(0, 15) == 0) in_burst = !in_burst;
        in_gap = in_burst ? 0 : $urandom_range(0, 18);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_seen != out_taken) begin
        out_seen = out_taken;
        if ($urandom_range(0, 15) == 0) out_burst = !out_burst;
        out_stall = out_burst ? 0 : $urandom_range(0, 18);
      end
      if (out_stall != 0) begin
        out_stall = out_stall - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) ways_reg[SEEN] = cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready) begin
        in_taken = in_taken + 1;
        seen_item.op      = merge_op_e'(s_axis_tuser[1:0]);
        seen_item.present = s_axis_tuser[2];
        seen_item.way     = s_axis_tdata[3:0];
        seen_item.key     = s_axis_tdata[67:4];
        seen_item.tag     = s_axis_tdata[99:68];
        if (merge_step(SEEN, seen_item, want_result)) expected_winners.push_back(want_result);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        out_taken = out_taken + 1;
        seen_result = {m_axis_tdata[3:0], m_axis_tdata[67:4], m_axis_tdata[99:68], m_axis_tuser};
        if (expected_winners.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, seen_result);
          errors++;
        end else begin
          want_result = expected_winners.pop_front();
          check_field("winner_way", 64'(want_result.way), 64'(seen_result.way));
          check_field("winner_key", want_result.key, seen_result.key);
          check_field("winner_tag", 64'(want_result.tag), 64'(seen_result.tag));
          check_field("merge_done", 64'(want_result.done), 64'(seen_result.done));
        end
      end
    end
  end

  initial begin
    merge_result_t res, junk;
    int unsigned   turns, phase;
    logic [4:0]    count;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    post_item(OP_LOAD, 4'd0, 64'd0, 32'd0, 1'b1, junk);
    post_item(OP_LOAD, 4'd15, '1, '1, 1'b1, junk);
    post_item(OP_LOAD, 4'd3, 64'd0, 32'h0000_1234, 1'b1, junk);
    post_item(OP_LOAD, 4'd7, 64'd5, 32'd7, 1'b0, junk);
    post_item(OP_LOAD, 4'd9, 64'h8000_0000_0000_0000, 32'h8000_0000, 1'b1, junk);
    post_item(OP_IDLE, 4'd15, '1, '1, 1'b1, junk);
    post_item(OP_BUILD, 4'd0, 64'd0, 32'd0, 1'b0, res);
    post_item(OP_REFILL, 4'd0, 64'd0, 32'd1, 1'b1, res);
    post_item(OP_REFILL, 4'd0, '1, 32'hffff_fffe, 1'b1, res);
    post_item(OP_LOAD, 4'd5, 64'd1, 32'd5, 1'b1, junk);
    turns = 0;
    while (!res.done && turns < 20) begin
      turns++;
      post_item(OP_REFILL, 4'd0, 64'd0, 32'd0, 1'b0, res);
    end
    post_item(OP_REFILL, 4'd10, rand_key(), $urandom, 1'b1, res);
    post_item(OP_LOAD, 4'd1, 64'd40, 32'd1, 1'b1, junk);
    post_item(OP_LOAD, 4'd2, 64'd20, 32'd2, 1'b1, junk);
    write_ways(5'd4);
    post_item(OP_REFILL, 4'd6, rand_key(), $urandom, 1'b1, res);
    post_item(OP_REFILL, 4'd12, 64'd3, $urandom, 1'b1, res);
    post_item(OP_BUILD, 4'd8, rand_key(), $urandom, 1'b1, res);

    phase = 0;
    while (items_posted < TARGET_ITEMS) begin
      if (phase < 6) count = first_counts[phase];
      else if ($urandom_range(0, 7) == 0) count = 5'($urandom_range(0, 31));
      else count = 5'($urandom_range(1, 16));
      write_ways(count);
      if (max_built >= active_ways(PLAN) && $urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          post_item(OP_REFILL, 4'($urandom), rand_key(), $urandom, 1'($urandom_range(0, 1)),
                    junk);
        end
      end
      run_merge();
      phase++;
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (expected_winners.size() != 0) begin
      $display("%0t: %0d results missing, expected %h, actual none", $time,
               expected_winners.size(), expected_winners[0]);
      errors++;
    end
    if (errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/kwm_pkg.sv
hw/rtl/kwm_dpath.sv
hw/rtl/kwm_ctrl.sv
hw/rtl/winner_tree_kway_merge.sv
tb/tb_top.sv
